>>> rtl/ld_pkg.sv
// shared types, constants and helpers for the levenshtein distance block
`default_nettype none

package ld_pkg;

    localparam int MAX_LEN_DEF = 32;
    localparam int SYM_W       = 8;
    localparam int DIST_W      = 16;
    localparam int OP_W        = 2;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_TEXT   = 2'd2;
    localparam logic [OP_W-1:0] OP_END    = 2'd3;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef struct packed {
        logic              valid;
        logic              is_end;
        logic [SYM_W-1:0]  symbol;
        logic [DIST_W-1:0] new_val;
        logic [DIST_W-1:0] old_val;
    } tok_t;

    function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v);
        logic [DIST_W-1:0] r;
        if (v == DIST_MAX)
            r = DIST_MAX;
        else
            r = v + {{(DIST_W-1){1'b0}}, 1'b1};
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/levenshtein_distance.sv
// top level of the levenshtein distance block: entry stage, cell chain, result register
`default_nettype none

// Edit distance between a stored pattern of up to MAX_LEN characters and each
// streamed text. Text characters and end-of-text items are taken one per cycle
// while the result is not stalled and travel as a wavefront down a chain of
// MAX_LEN cells, one cell per pattern position; an end-of-text item passes the
// entry stage and the cells up to the pattern length before its distance is
// registered in the result register. A clear or append item waits until the
// chain is empty. A stalled result holds the whole chain.

module levenshtein_distance #(
    parameter int MAX_LEN = ld_pkg::MAX_LEN_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [ld_pkg::OP_W-1:0]       op,
    input  wire logic [ld_pkg::SYM_W-1:0]      symbol,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [ld_pkg::DIST_W-1:0]          edit_distance
);

    localparam int IDX_W = $clog2(MAX_LEN + 1);

    ld_pkg::tok_t              tok [MAX_LEN+1];
    logic [MAX_LEN:0]          busy_vec;
    logic                      busy;
    logic                      advance;
    logic                      accept;
    logic                      pat_op;
    logic                      restart;
    logic                      append_go;

    logic [IDX_W-1:0]          len_reg;
    logic [IDX_W-1:0]          len_next;
    logic [ld_pkg::DIST_W-1:0] row0_reg;
    logic [ld_pkg::DIST_W-1:0] row0_next;
    ld_pkg::tok_t              tok0_reg;
    ld_pkg::tok_t              tok0_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [ld_pkg::DIST_W-1:0] dist_reg;
    ld_pkg::tok_t              sel_tok;

    assign advance  = !out_valid_reg || !out_stall;
    assign pat_op   = (op == ld_pkg::OP_CLEAR) || (op == ld_pkg::OP_APPEND);
    assign busy     = |busy_vec;
    assign in_stall = !advance || (pat_op && busy);
    assign accept   = in_valid && !in_stall;

    assign append_go = accept && (op == ld_pkg::OP_APPEND) && (len_reg < IDX_W'(MAX_LEN));
    assign restart   = (accept && (op == ld_pkg::OP_CLEAR)) || append_go;

    always_comb
    begin
        len_next = len_reg;
        if (accept && (op == ld_pkg::OP_CLEAR))
            len_next = '0;
        else if (append_go)
            len_next = len_reg + {{(IDX_W-1){1'b0}}, 1'b1};
    end

    // entry stage: row entry zero
    always_comb
    begin
        row0_next         = row0_reg;
        tok0_next.valid   = accept && !pat_op;
        tok0_next.is_end  = (op == ld_pkg::OP_END);
        tok0_next.symbol  = symbol;
        tok0_next.old_val = row0_reg;
        tok0_next.new_val = row0_reg;
        if (restart)
        begin
            row0_next = '0;
        end
        else if (tok0_next.valid)
        begin
            if (tok0_next.is_end)
            begin
                row0_next = '0;
            end
            else
            begin
                row0_next         = ld_pkg::sat_inc(row0_reg);
                tok0_next.new_val = row0_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            row0_reg      <= '0;
            tok0_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg       <= len_next;
            row0_reg      <= row0_next;
            out_valid_reg <= out_valid_next;
            if (advance)
                tok0_reg <= tok0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && sel_tok.valid && sel_tok.is_end)
            dist_reg <= sel_tok.old_val;
    end

    assign tok[0]      = tok0_reg;
    assign busy_vec[0] = tok0_reg.valid;

    genvar j;
    generate
        for (j = 1; j <= MAX_LEN; j++)
        begin : g_cell
            ld_cell #(
                .MAX_LEN (MAX_LEN)
            ) u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .advance (advance),
                .restart (restart),
                .index   (IDX_W'(j)),
                .wr_en   (append_go && (len_reg == IDX_W'(j - 1))),
                .wr_sym  (symbol),
                .in_tok  (tok[j-1]),
                .out_tok (tok[j])
            );
            assign busy_vec[j] = tok[j].valid;
        end
    endgenerate

    // the result leaves the cell at the end of the pattern
    assign sel_tok = tok[len_reg];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = sel_tok.valid && sel_tok.is_end;
    end

    assign out_valid     = out_valid_reg;
    assign edit_distance = dist_reg;

endmodule

`default_nettype wire

>>> rtl/ld_cell.sv
// one column cell of the distance row: holds a pattern char and one row entry
`default_nettype none

module ld_cell #(
    parameter int MAX_LEN = ld_pkg::MAX_LEN_DEF,
    localparam int IDX_W  = $clog2(MAX_LEN + 1)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         advance,
    input  wire logic                         restart,
    input  wire logic [IDX_W-1:0]             index,
    input  wire logic                         wr_en,
    input  wire logic [ld_pkg::SYM_W-1:0]     wr_sym,
    input  wire ld_pkg::tok_t                 in_tok,
    output ld_pkg::tok_t                      out_tok
);

    logic [ld_pkg::DIST_W-1:0] value_reg;
    logic [ld_pkg::DIST_W-1:0] value_next;
    logic [ld_pkg::SYM_W-1:0]  pchar_reg;
    ld_pkg::tok_t              tok_reg;
    ld_pkg::tok_t              tok_next;
    logic [ld_pkg::DIST_W-1:0] home_val;
    logic [ld_pkg::DIST_W-1:0] min_ul;
    logic [ld_pkg::DIST_W-1:0] min_all;
    logic [ld_pkg::DIST_W-1:0] text_val;

    assign home_val = ld_pkg::DIST_W'(index);

    always_comb
    begin
        min_ul  = (in_tok.new_val < value_reg) ? in_tok.new_val : value_reg;
        min_all = (in_tok.old_val < min_ul) ? in_tok.old_val : min_ul;
        if (pchar_reg == in_tok.symbol)
            text_val = in_tok.old_val;
        else
            text_val = ld_pkg::sat_inc(min_all);
    end

    always_comb
    begin
        value_next       = value_reg;
        tok_next         = in_tok;
        tok_next.old_val = value_reg;
        tok_next.new_val = value_reg;
        if (restart)
        begin
            value_next = home_val;
        end
        else if (advance && in_tok.valid)
        begin
            if (in_tok.is_end)
            begin
                value_next = home_val;
            end
            else
            begin
                value_next       = text_val;
                tok_next.new_val = text_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= home_val;
            tok_reg   <= '0;
        end
        else
        begin
            value_reg <= value_next;
            if (advance)
                tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            pchar_reg <= wr_sym;
    end

    assign out_tok = tok_reg;

endmodule

`default_nettype wire
